@@ rtl/sfm_pkg.sv @@
// shared types, constants and helpers for the substring first-match block
package sfm_pkg;

    // search geometry
    localparam int PATTERN_MAX   = 16;
    localparam int POSITION_BITS = 16;
    localparam int LEN_W         = $clog2(PATTERN_MAX + 1);

    // fixed field and register widths
    localparam int BYTE_W     = 8;
    localparam int CFG_W      = 64;
    localparam int CFG_IDX_W  = 2;
    localparam int PLEN_W     = 5;
    localparam int PAT_BYTES  = 16;
    localparam int PAT_W      = PAT_BYTES * BYTE_W;
    localparam int START_W    = 16;
    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 24;

    localparam logic [POSITION_BITS-1:0] POS_MAX = {POSITION_BITS{1'b1}};

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LOW  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_HIGH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LEN  = 2'd2;

    // one classified byte passed from front to back
    typedef struct packed {
        logic                     hit;
        logic [POSITION_BITS-1:0] start;
        logic                     last;
    } sfm_entry_t;

    // pattern byte k, zero beyond the stored pattern
    function automatic logic [BYTE_W-1:0] pattern_byte(
        input logic [PAT_W-1:0] pat,
        input int unsigned      k
    );
        logic [BYTE_W-1:0] sel;
        sel = '0;
        for (int unsigned i = 0; i < PAT_BYTES; i++)
        begin
            if (k == i)
            begin
                sel = pat[i*BYTE_W +: BYTE_W];
            end
        end
        return sel;
    endfunction

endpackage

@@ rtl/sfm_front.sv @@
// front end: config registers, byte history, position count and match classification
module sfm_front (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [sfm_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [sfm_pkg::CFG_W-1:0]      cfg_data,
    input  logic                           accept,
    input  logic [sfm_pkg::BYTE_W-1:0]     text_byte,
    input  logic                           text_last,
    output sfm_pkg::sfm_entry_t            entry
);
    import sfm_pkg::*;

    logic [CFG_W-1:0]         pat_low_reg;
    logic [CFG_W-1:0]         pat_high_reg;
    logic [PLEN_W-1:0]        pat_len_reg;
    logic [BYTE_W-1:0]        hist_reg  [PATTERN_MAX];
    logic [BYTE_W-1:0]        hist_next [PATTERN_MAX];
    logic [POSITION_BITS-1:0] pos_reg;
    logic [POSITION_BITS-1:0] pos_next;
    logic [LEN_W-1:0]         len_eff;
    logic [PAT_W-1:0]         pattern;
    logic                     cmp_ok;
    logic                     long_enough;

    // configuration writes, unknown indexes ignored
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pat_low_reg  <= '0;
            pat_high_reg <= '0;
            pat_len_reg  <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_PATTERN_LOW:  pat_low_reg  <= cfg_data;
                REG_PATTERN_HIGH: pat_high_reg <= cfg_data;
                REG_PATTERN_LEN:  pat_len_reg  <= cfg_data[PLEN_W-1:0];
                default:          ;
            endcase
        end
    end

    assign pattern = {pat_high_reg, pat_low_reg};

    // length clamped to the history depth
    always_comb
    begin
        if (int'(pat_len_reg) > PATTERN_MAX)
        begin
            len_eff = LEN_W'(PATTERN_MAX);
        end
        else
        begin
            len_eff = LEN_W'(pat_len_reg);
        end
    end

    // history with the new byte shifted in at entry 0
    always_comb
    begin
        hist_next[0] = text_byte;
        for (int j = 1; j < PATTERN_MAX; j++)
        begin
            hist_next[j] = hist_reg[j-1];
        end
    end

    // compare each history entry below the effective length with its aligned pattern byte
    always_comb
    begin
        cmp_ok = 1'b1;
        for (int j = 0; j < PATTERN_MAX; j++)
        begin
            if (j < int'(len_eff))
            begin
                if (hist_next[j] != pattern_byte(pattern, int'(len_eff) - 1 - j))
                begin
                    cmp_ok = 1'b0;
                end
            end
        end
    end

    assign long_enough = (len_eff != '0) &&
        ({1'b0, pos_reg} >= ((POSITION_BITS+1)'(len_eff) - (POSITION_BITS+1)'(1)));

    // classified entry for the queue
    always_comb
    begin
        entry.hit  = long_enough && cmp_ok;
        entry.last = text_last;
        if (pos_reg == POS_MAX)
        begin
            entry.start = POS_MAX;
        end
        else
        begin
            entry.start = pos_reg - POSITION_BITS'(len_eff) + POSITION_BITS'(1);
        end
    end

    // saturating position count
    assign pos_next = (pos_reg == POS_MAX) ? pos_reg : pos_reg + POSITION_BITS'(1);

    // per-text state, cleared after the last byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
            for (int j = 0; j < PATTERN_MAX; j++)
            begin
                hist_reg[j] <= '0;
            end
        end
        else if (accept)
        begin
            if (text_last)
            begin
                pos_reg <= '0;
                for (int j = 0; j < PATTERN_MAX; j++)
                begin
                    hist_reg[j] <= '0;
                end
            end
            else
            begin
                pos_reg <= pos_next;
                for (int j = 0; j < PATTERN_MAX; j++)
                begin
                    hist_reg[j] <= hist_next[j];
                end
            end
        end
    end

endmodule

@@ rtl/sfm_queue.sv @@
// two-entry queue between front and back
module sfm_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  sfm_pkg::sfm_entry_t push_data,
    output logic                full,
    input  logic                pop,
    output logic                not_empty,
    output sfm_pkg::sfm_entry_t pop_data
);
    import sfm_pkg::*;

    sfm_entry_t  mem_reg [2];
    logic        wr_ptr_reg;
    logic        rd_ptr_reg;
    logic [1:0]  count_reg;
    logic [1:0]  count_next;

    assign full      = (count_reg == 2'd2);
    assign not_empty = (count_reg != 2'd0);
    assign pop_data  = mem_reg[rd_ptr_reg];

    // occupancy update
    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    // pointers and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

@@ rtl/sfm_back.sv @@
// back end: sticky found flag, first start position and output register
module sfm_back (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           q_valid,
    input  sfm_pkg::sfm_entry_t            q_data,
    output logic                           q_pop,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [sfm_pkg::OUT_TDATA_W-1:0] m_tdata,
    output logic                           m_tlast
);
    import sfm_pkg::*;

    logic                     found_reg;
    logic [POSITION_BITS-1:0] first_reg;
    logic                     out_valid_reg;
    logic                     now_reg;
    logic                     found_out_reg;
    logic [START_W-1:0]       start_out_reg;
    logic                     done_reg;
    logic                     now_next;
    logic                     found_next;
    logic [POSITION_BITS-1:0] first_next;

    // take an entry whenever the output register is free or drains now
    assign q_pop = q_valid && (!out_valid_reg || m_tready);

    // first occurrence bookkeeping
    always_comb
    begin
        now_next   = q_data.hit && !found_reg;
        found_next = found_reg || q_data.hit;
        first_next = now_next ? q_data.start : first_reg;
    end

    // sticky state, cleared after the last byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            found_reg <= 1'b0;
            first_reg <= '0;
        end
        else if (q_pop)
        begin
            if (q_data.last)
            begin
                found_reg <= 1'b0;
                first_reg <= '0;
            end
            else
            begin
                found_reg <= found_next;
                first_reg <= first_next;
            end
        end
    end

    // output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (q_pop)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // output payload
    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            now_reg       <= now_next;
            found_out_reg <= found_next;
            start_out_reg <= found_next ? START_W'(first_next) : '0;
            done_reg      <= q_data.last;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tlast  = done_reg;
    assign m_tdata  = {(OUT_TDATA_W-START_W-2)'(0), start_out_reg, found_out_reg, now_reg};

endmodule

@@ rtl/substring_first_match_top.sv @@
// top level of the substring first-match search block
//
//  channel   | direction | handshake            | payload
//  ----------+-----------+----------------------+---------------------------------------
//  s_axis    | in        | tvalid/tready        | tdata: text_byte; tlast: text_last
//  m_axis    | out       | tvalid/tready        | tdata: match_now, found_so_far,
//            |           |                      |        match_start; tlast: text_done
//  cfg       | in        | cfg_we (no wait)     | cfg_index, cfg_data
//
//  one text byte per cycle while s_axis_tready is high; the queue is written at the accept
//  edge and the output register when the back end pops the entry from the queue
//  the front compares the pattern bytes within the length against the history in the accept cycle
//  reset clears config, history, position, found flag, queue and output valid
//  a stalled output fills the two-entry queue, then s_axis_tready drops
module substring_first_match_top (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [sfm_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [sfm_pkg::CFG_W-1:0]        cfg_data,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [sfm_pkg::IN_TDATA_W-1:0]   s_axis_tdata,  // [7:0] text_byte
    input  logic                             s_axis_tlast,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [sfm_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,  // [0] match_now,
                                                            // [1] found_so_far,
                                                            // [17:2] match_start
    output logic                             m_axis_tlast
);
    import sfm_pkg::*;

    sfm_entry_t front_entry;
    sfm_entry_t q_data;
    logic       q_full;
    logic       q_valid;
    logic       q_pop;
    logic       accept;

    assign s_axis_tready = !q_full;
    assign accept        = s_axis_tvalid && !q_full;

    // classify each accepted byte
    sfm_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .accept    (accept),
        .text_byte (s_axis_tdata[BYTE_W-1:0]),
        .text_last (s_axis_tlast),
        .entry     (front_entry)
    );

    // decouple front from back
    sfm_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (accept),
        .push_data (front_entry),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_valid),
        .pop_data  (q_data)
    );

    // resolve first occurrence and drive results
    sfm_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_valid  (q_valid),
        .q_data   (q_data),
        .q_pop    (q_pop),
        .m_tvalid (m_axis_tvalid),
        .m_tready (m_axis_tready),
        .m_tdata  (m_axis_tdata),
        .m_tlast  (m_axis_tlast)
    );

endmodule

@@ tb/sfm_search_checker.sv @@
// checker for the substring first-match block: predicts each result and compares it
module sfm_search_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [sfm_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [sfm_pkg::CFG_W-1:0]       cfg_data,
    input  logic                            s_axis_tvalid,
    input  logic                            s_axis_tready,
    input  logic [sfm_pkg::IN_TDATA_W-1:0]  s_axis_tdata,  // [7:0] text_byte
    input  logic                            s_axis_tlast,
    input  logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    input  logic [sfm_pkg::OUT_TDATA_W-1:0] m_axis_tdata,  // [0] match_now, [1] found_so_far,
                                                           // [17:2] match_start
    input  logic                            m_axis_tlast,
    output int                              fail_count,
    output int                              pending,
    output int                              results_checked,
    output int                              first_matches
);
    timeunit 1ns;
    timeprecision 1ps;

    import sfm_pkg::*;

    // result layout inside m_axis_tdata
    localparam int MATCH_BIT  = 0;
    localparam int FOUND_BIT  = 1;
    localparam int START_LSB  = 2;
    localparam int PRINT_MAX  = 50;

    typedef struct packed {
        logic               match_now;
        logic               found;
        logic [START_W-1:0] start;
        logic               done;
    } search_result_t;

    // configuration as last written
    logic [CFG_W-1:0]         pattern_low;
    logic [CFG_W-1:0]         pattern_high;
    logic [PLEN_W-1:0]        pattern_len;

    // per-text search state
    logic [BYTE_W-1:0]        history [PATTERN_MAX];
    logic [POSITION_BITS-1:0] position;
    logic                     found_flag;
    logic [POSITION_BITS-1:0] first_start;

    search_result_t           expected_results [$];

    // one line per mismatch, printing capped, counting not
    task automatic report_mismatch(input string what, input longint unsigned got,
                                   input longint unsigned want);
        if (fail_count < PRINT_MAX)
        begin
            $display("checker: result %0d %s: got %0h, expected %0h",
                     results_checked, what, got, want);
        end
        fail_count++;
    endtask

    function automatic void clear_text();
        for (int i = 0; i < PATTERN_MAX; i++)
        begin
            history[i] = '0;
        end
        position    = '0;
        found_flag  = 1'b0;
        first_start = '0;
    endfunction

    // advance the search by one text byte and return the result it yields
    function automatic search_result_t predict_search(input logic [BYTE_W-1:0] text_byte,
                                                      input logic text_last);
        logic [PAT_W-1:0] pattern_word;
        int unsigned      span;
        logic             hit;
        search_result_t   res;
        pattern_word = {pattern_high, pattern_low};
        span = (pattern_len > PATTERN_MAX) ? PATTERN_MAX : pattern_len;

        // newest byte at entry 0
        for (int i = PATTERN_MAX - 1; i > 0; i--)
        begin
            history[i] = history[i-1];
        end
        history[0] = text_byte;

        // compare the last span bytes against the pattern
        hit = (span != 0) && (position >= span - 1);
        for (int unsigned k = 0; k < span; k++)
        begin
            if (pattern_word[k*BYTE_W +: BYTE_W] != history[span-1-k])
            begin
                hit = 1'b0;
            end
        end

        res.match_now = hit && !found_flag;
        if (res.match_now)
        begin
            found_flag  = 1'b1;
            first_start = (position == POS_MAX) ? POS_MAX
                                                : POSITION_BITS'(position + 1 - span);
        end
        res.found = found_flag;
        res.start = found_flag ? START_W'(first_start) : '0;
        res.done  = text_last;

        if (position != POS_MAX)
        begin
            position++;
        end
        if (text_last)
        begin
            clear_text();
        end
        return res;
    endfunction

    // watch config writes, accepted results and accepted text bytes
    always @(posedge clk or negedge rst_n)
    begin
        search_result_t got;
        search_result_t want;
        if (!rst_n)
        begin
            pattern_low  = '0;
            pattern_high = '0;
            pattern_len  = '0;
            clear_text();
            expected_results.delete();
            fail_count      = 0;
            pending         = 0;
            results_checked = 0;
            first_matches   = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_PATTERN_LOW:  pattern_low  = cfg_data;
                    REG_PATTERN_HIGH: pattern_high = cfg_data;
                    REG_PATTERN_LEN:  pattern_len  = cfg_data[PLEN_W-1:0];
                    default:          ;
                endcase
            end

            if (m_axis_tvalid && m_axis_tready)
            begin
                got.match_now = m_axis_tdata[MATCH_BIT];
                got.found     = m_axis_tdata[FOUND_BIT];
                got.start     = m_axis_tdata[START_LSB +: START_W];
                got.done      = m_axis_tlast;
                if (expected_results.size() == 0)
                begin
                    report_mismatch("arrived with nothing expected", got, 0);
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (got.match_now !== want.match_now)
                    begin
                        report_mismatch("match_now", got.match_now, want.match_now);
                    end
                    if (got.found !== want.found)
                    begin
                        report_mismatch("found_so_far", got.found, want.found);
                    end
                    if (got.start !== want.start)
                    begin
                        report_mismatch("match_start", got.start, want.start);
                    end
                    if (got.done !== want.done)
                    begin
                        report_mismatch("text_done", got.done, want.done);
                    end
                    if (want.match_now)
                    begin
                        first_matches++;
                    end
                    results_checked++;
                end
            end

            if (s_axis_tvalid && s_axis_tready)
            begin
                expected_results.push_back(predict_search(s_axis_tdata[BYTE_W-1:0],
                                                          s_axis_tlast));
            end
            pending = expected_results.size();
        end
    end

endmodule

@@ tb/testbench.sv @@
// top of the testbench: clock, reset, text stimulus, result sink and verdict
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import sfm_pkg::*;

    localparam logic [CFG_IDX_W-1:0] REG_SPARE = REG_PATTERN_LEN + 1'b1;  // no register here
    localparam int LEN_FIELD_MAX  = (1 << PLEN_W) - 1;
    localparam int GAP_MAX        = 13;
    localparam int PHASES         = 8;
    localparam int PHASE_ITEMS    = 125;
    localparam int HOLD_AFTER     = 350;
    localparam int HOLD_CYCLES    = 250;
    localparam int DRAIN_CYCLES   = 6;
    localparam int TIMEOUT_CYCLES = 1_000_000;
    localparam int SAT_FILL       = int'(POS_MAX) + 2;

    logic                    clk           = 1'b0;
    logic                    rst_n         = 1'b0;
    logic                    cfg_we        = 1'b0;
    logic [CFG_IDX_W-1:0]    cfg_index     = '0;
    logic [CFG_W-1:0]        cfg_data      = '0;
    logic                    s_axis_tvalid = 1'b0;
    logic                    s_axis_tready;
    logic [IN_TDATA_W-1:0]   s_axis_tdata  = '0;   // [7:0] text_byte
    logic                    s_axis_tlast  = 1'b0;
    logic                    m_axis_tvalid;
    logic                    m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0]  m_axis_tdata;         // [0] match_now, [1] found_so_far,
                                                   // [17:2] match_start
    logic                    m_axis_tlast;

    int                      fail_count;
    int                      pending;
    int                      results_checked;
    int                      first_matches;

    // stimulus state
    logic                    no_gaps = 1'b0;
    logic [PAT_W-1:0]        pattern_word = '0;
    int unsigned             span = 0;
    logic [BYTE_W-1:0]       alphabet [3];
    logic [BYTE_W-1:0]       text_bytes [$];
    int unsigned             items_sent = 0;
    int unsigned             texts_sent = 0;
    int unsigned             settings_used = 0;
    int unsigned             longest_text = 0;
    int unsigned             cycle_count = 0;

    substring_first_match_top u_dut (.*);

    sfm_search_checker u_checker (.*);

    // clock
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= TIMEOUT_CYCLES)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    // result sink: random stalls, one long hold-off to back the block up
    initial
    begin
        int unsigned stall;
        int unsigned taken;
        taken = 0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (taken == HOLD_AFTER)
            begin
                stall = HOLD_CYCLES;
            end
            else if (no_gaps)
            begin
                stall = 0;
            end
            else
            begin
                stall = $urandom_range(0, GAP_MAX);
            end
            if (stall != 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            @(posedge clk);
            while (!m_axis_tvalid)
            begin
                @(posedge clk);
            end
            taken++;
        end
    end

    // offer one text byte after a random gap and wait until it is taken
    task automatic send_byte(input logic [BYTE_W-1:0] value, input logic last);
        int unsigned gap;
        gap = no_gaps ? 0 : $urandom_range(0, GAP_MAX);
        if (gap != 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= value;
        s_axis_tlast  <= last;
        @(posedge clk);
        while (!s_axis_tready)
        begin
            @(posedge clk);
        end
        items_sent++;
    endtask

    task automatic send_text(input logic close);
        int unsigned n;
        n = text_bytes.size();
        for (int unsigned i = 0; i < n; i++)
        begin
            send_byte(text_bytes[i], close && (i == n - 1));
        end
        if (close)
        begin
            texts_sent++;
        end
        if (n > longest_text)
        begin
            longest_text = n;
        end
        text_bytes.delete();
    endtask

    // stop sending and wait until every expected result is back
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        do
        begin
            @(negedge clk);
        end
        while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // write all pattern registers plus the unused index, block idle
    task automatic load_pattern(input logic [CFG_W-1:0] low, input logic [CFG_W-1:0] high,
                                input logic [PLEN_W-1:0] len);
        cfg_we    <= 1'b1;
        cfg_index <= REG_PATTERN_LOW;
        cfg_data  <= low;
        @(posedge clk);
        cfg_index <= REG_PATTERN_HIGH;
        cfg_data  <= high;
        @(posedge clk);
        // junk above the length field must be dropped
        cfg_index <= REG_PATTERN_LEN;
        cfg_data  <= {$urandom, 27'($urandom), len};
        @(posedge clk);
        cfg_index <= REG_SPARE;
        cfg_data  <= {$urandom, $urandom};
        @(posedge clk);
        cfg_we    <= 1'b0;
        pattern_word = {high, low};
        span = (len > PATTERN_MAX) ? PATTERN_MAX : len;
        settings_used++;
    endtask

    // build one text: mostly alphabet text with planted pattern copies,
    // sometimes a pattern cut short, sometimes noise that may run on
    task automatic make_text(output logic close);
        int unsigned kind;
        int unsigned tlen;
        int unsigned copies;
        int unsigned off;
        kind  = $urandom_range(0, 9);
        close = 1'b1;
        if (kind < 8)
        begin
            tlen = $urandom_range(1, 2 * span + 6);
            for (int unsigned i = 0; i < tlen; i++)
            begin
                text_bytes.push_back(($urandom_range(0, 7) == 0) ? BYTE_W'($urandom)
                                                                : alphabet[$urandom_range(0, 2)]);
            end
            copies = (span != 0 && tlen >= span) ? $urandom_range(0, 2) : 0;
            repeat (copies)
            begin
                off = $urandom_range(0, tlen - span);
                for (int unsigned k = 0; k < span; k++)
                begin
                    text_bytes[off + k] = pattern_word[k*BYTE_W +: BYTE_W];
                end
            end
        end
        else if (kind == 8)
        begin
            for (int unsigned k = 0; k + 1 < span; k++)
            begin
                text_bytes.push_back(pattern_word[k*BYTE_W +: BYTE_W]);
            end
            if (text_bytes.size() == 0)
            begin
                text_bytes.push_back(alphabet[0]);
            end
        end
        else
        begin
            tlen = $urandom_range(1, 12);
            repeat (tlen)
            begin
                text_bytes.push_back(BYTE_W'($urandom));
            end
            close = $urandom_range(0, 1);
        end
    endtask

    // main sequence
    initial
    begin
        logic [PAT_W-1:0]  pat;
        logic [PLEN_W-1:0] len;
        logic              close;
        int unsigned       phase_start;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // zero length never matches, even on bytes equal to the stored pattern
        load_pattern('1, '0, '0);
        text_bytes = '{8'hFF, 8'hFF, 8'hFF};
        send_text(1'b1);
        drain();

        // zero bytes in the pattern: short text, match on the final byte, later occurrence
        load_pattern(64'h0000_0000_0000_FF00, '1, 5'd3);
        text_bytes = '{8'h00, 8'hFF};
        send_text(1'b1);
        text_bytes = '{8'h00, 8'hFF, 8'h00};
        send_text(1'b1);
        text_bytes = '{8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00};
        send_text(1'b1);
        drain();

        // length field above the maximum acts as full length
        load_pattern(64'h8877_6655_4433_2211, 64'h01F0_E1D2_C3B4_A596, PLEN_W'(LEN_FIELD_MAX));
        for (int unsigned k = 0; k < PATTERN_MAX; k++)
        begin
            text_bytes.push_back(pattern_word[k*BYTE_W +: BYTE_W]);
        end
        send_text(1'b1);
        drain();

        // random phases, each with its own pattern and alphabet
        for (int p = 0; p < PHASES; p++)
        begin
            alphabet[0] = (p == 0) ? 8'h00 : BYTE_W'($urandom);
            alphabet[1] = (p == 0) ? 8'hFF : BYTE_W'($urandom);
            alphabet[2] = BYTE_W'($urandom);
            for (int unsigned k = 0; k < PATTERN_MAX; k++)
            begin
                pat[k*BYTE_W +: BYTE_W] = ($urandom_range(0, 3) == 0) ? BYTE_W'($urandom)
                                                                      : alphabet[$urandom_range(0, 2)];
            end
            case (p)
                0:       len = 5'd1;
                1:       len = PLEN_W'(PATTERN_MAX);
                3:       len = PLEN_W'($urandom_range(PATTERN_MAX + 1, LEN_FIELD_MAX));
                5:       len = '0;
                default: len = PLEN_W'($urandom_range(2, PATTERN_MAX - 1));
            endcase
            no_gaps = (p == 2);
            load_pattern(pat[CFG_W-1:0], pat[PAT_W-1:CFG_W], len);
            phase_start = items_sent;
            while (items_sent - phase_start < PHASE_ITEMS)
            begin
                make_text(close);
                send_text(close);
            end
            drain();
        end

        // one long text that drives the position counter into saturation,
        // then a match found while saturated, then a short text after clearing
        no_gaps = 1'b1;
        load_pattern(64'h4241, '0, 5'd2);
        for (int i = 0; i < SAT_FILL; i++)
        begin
            send_byte(8'h00, 1'b0);
        end
        send_byte(8'h41, 1'b0);
        send_byte(8'h42, 1'b1);
        texts_sent++;
        text_bytes = '{8'h41, 8'h42};
        send_text(1'b1);
        drain();

        $display("tb: %0d text bytes in %0d texts under %0d pattern settings, longest text %0d",
                 items_sent, texts_sent, settings_used, SAT_FILL + 2);
        $display("tb: %0d results checked, %0d first matches, %0d mismatches",
                 results_checked, first_matches, fail_count);
        if (fail_count == 0)
        begin
            $display("tb: success");
        end
        else
        begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
